// ----- rtl/sgmpca_pkg.sv -----
// ----------------------------------------------------------------------------
// sgmpca_pkg
// Shared types, constants and helpers of the path cost aggregation block.
// ----------------------------------------------------------------------------
package sgmpca_pkg;

  localparam int NUM_DISP    = 64;
  localparam int DISP_W      = $clog2(NUM_DISP);
  localparam int COST_W      = 8;
  localparam int DISP_OUT_W  = 6;
  localparam int MEM_AW      = DISP_W + 1;
  localparam int MEM_DEPTH   = 2 ** MEM_AW;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 16;

  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [COST_W-1:0] SAT_MAX           = 8'hFF;
  localparam logic [COST_W-1:0] SMALL_PENALTY_RST = 8'd40;
  localparam logic [COST_W-1:0] LARGE_PENALTY_RST = 8'd200;
  localparam logic [DISP_W-1:0] LAST_DISP         = DISP_W'(NUM_DISP - 1);

  // register select, taken from paddr[2]
  localparam logic REG_SMALL_PENALTY = 1'b0;
  localparam logic REG_LARGE_PENALTY = 1'b1;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [DISP_W-1:0] disp;
    logic              first;
    logic              last;
    logic              bank;
  } item_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[COST_W] ? SAT_MAX : sum[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] min2(input logic [COST_W-1:0] a,
                                             input logic [COST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- rtl/sgmpca_front.sv -----
// ----------------------------------------------------------------------------
// sgmpca_front
// Input stage: tags each cost with its disparity, pixel bank and path flags.
// ----------------------------------------------------------------------------
module sgmpca_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sgmpca_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] match_cost
  input  logic [sgmpca_pkg::IN_TUSER_W-1:0]   s_tuser,  // [0] path_start
  input  logic                                q_full,
  output logic                                q_push,
  output sgmpca_pkg::item_t                   q_item
);

  logic [sgmpca_pkg::DISP_W-1:0] disp;
  logic                          first;
  logic                          bank;
  logic                          item_first;
  logic                          item_last;

  assign s_tready   = !q_full;
  assign q_push     = s_tvalid && s_tready;
  assign item_first = (disp == '0) ? (s_tuser[0] || first) : first;
  assign item_last  = (disp == sgmpca_pkg::LAST_DISP);

  always_comb begin
    q_item       = '0;
    q_item.cost  = s_tdata[sgmpca_pkg::COST_W-1:0];
    q_item.disp  = disp;
    q_item.first = item_first;
    q_item.last  = item_last;
    q_item.bank  = bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disp  <= '0;
      first <= 1'b1;
      bank  <= 1'b0;
    end else if (q_push) begin
      if (item_last) begin
        disp  <= '0;
        first <= 1'b0;
        bank  <= ~bank;
      end else begin
        disp  <= disp + sgmpca_pkg::DISP_W'(1);
        first <= item_first;
      end
    end
  end

endmodule

// ----- rtl/sgmpca_queue.sv -----
// ----------------------------------------------------------------------------
// sgmpca_queue
// Small FIFO of tagged items between the input and aggregation stages.
// ----------------------------------------------------------------------------
module sgmpca_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sgmpca_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output sgmpca_pkg::item_t head
);

  sgmpca_pkg::item_t                  slots [sgmpca_pkg::QUEUE_DEPTH];
  logic [sgmpca_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [sgmpca_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [sgmpca_pkg::QUEUE_AW:0]      count;

  assign full  = (count == (sgmpca_pkg::QUEUE_AW+1)'(sgmpca_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sgmpca_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sgmpca_pkg::QUEUE_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (sgmpca_pkg::QUEUE_AW+1)'(1);
        2'b01:   count <= count - (sgmpca_pkg::QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/sgmpca_back.sv -----
// ----------------------------------------------------------------------------
// sgmpca_back
// Aggregation stage: previous-vector store, penalty minimum, output register.
// ----------------------------------------------------------------------------
module sgmpca_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sgmpca_pkg::COST_W-1:0]       small_penalty,
  input  logic [sgmpca_pkg::COST_W-1:0]       large_penalty,
  input  logic                                q_valid,
  input  sgmpca_pkg::item_t                   q_item,
  output logic                                q_pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sgmpca_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [7:0] path_cost, [13:8] disparity
  output logic                                m_tlast   // pixel_done
);

  logic [sgmpca_pkg::COST_W-1:0] mem [sgmpca_pkg::MEM_DEPTH];

  sgmpca_pkg::item_t             s1;
  logic                          s1_valid;
  logic                          s1_fire;
  logic [sgmpca_pkg::COST_W-1:0] rd_data;
  logic [sgmpca_pkg::MEM_AW-1:0] rd_addr;
  logic [sgmpca_pkg::MEM_AW-1:0] wr_addr;

  logic [sgmpca_pkg::COST_W-1:0] win_left;
  logic [sgmpca_pkg::COST_W-1:0] win_mid;
  logic [sgmpca_pkg::COST_W-1:0] cur0;
  logic [sgmpca_pkg::COST_W-1:0] prev0;
  logic [sgmpca_pkg::COST_W-1:0] prev_min;
  logic [sgmpca_pkg::COST_W-1:0] run_min;
  logic [sgmpca_pkg::COST_W-1:0] run_min_next;

  logic                          at_zero;
  logic [sgmpca_pkg::COST_W-1:0] mid;
  logic [sgmpca_pkg::COST_W-1:0] left;
  logic [sgmpca_pkg::COST_W-1:0] right;
  logic [sgmpca_pkg::COST_W-1:0] jump;
  logic [sgmpca_pkg::COST_W-1:0] best;
  logic [sgmpca_pkg::COST_W-1:0] bound;
  logic [sgmpca_pkg::COST_W-1:0] excess;
  logic [sgmpca_pkg::COST_W-1:0] res;

  assign s1_fire = s1_valid && (!m_tvalid || m_tready);
  assign q_pop   = q_valid && (!s1_valid || s1_fire);
  assign rd_addr = {~q_item.bank, q_item.disp + sgmpca_pkg::DISP_W'(1)};
  assign wr_addr = {s1.bank, s1.disp};

  always_comb begin
    at_zero      = (s1.disp == '0);
    mid          = at_zero ? prev0 : win_mid;
    left         = at_zero ? sgmpca_pkg::SAT_MAX
                           : sgmpca_pkg::sat_add(win_left, small_penalty);
    right        = s1.last ? sgmpca_pkg::SAT_MAX
                           : sgmpca_pkg::sat_add(rd_data, small_penalty);
    jump         = sgmpca_pkg::sat_add(prev_min, large_penalty);
    best         = sgmpca_pkg::min2(sgmpca_pkg::min2(mid, left),
                                    sgmpca_pkg::min2(right, jump));
    bound        = (best < prev_min) ? prev_min : best;
    excess       = bound - prev_min;
    res          = s1.first ? s1.cost : sgmpca_pkg::sat_add(s1.cost, excess);
    run_min_next = at_zero ? res : sgmpca_pkg::min2(run_min, res);
  end

  // vector store: read the right neighbor on entry, write the result on exit
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mem[wr_addr] <= res;
    end
    if (q_pop) begin
      s1 <= q_item;
      if (s1_fire && (wr_addr == rd_addr)) begin
        rd_data <= res;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      win_left <= mid;
      win_mid  <= rd_data;
      if (at_zero) begin
        cur0 <= res;
      end
      if (s1.last) begin
        prev0 <= cur0;
      end
      m_tdata <= sgmpca_pkg::OUT_TDATA_W'({sgmpca_pkg::DISP_OUT_W'(s1.disp), res});
      m_tlast <= s1.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      prev_min <= '0;
      run_min  <= sgmpca_pkg::SAT_MAX;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s1_fire) begin
        if (s1.last) begin
          prev_min <= run_min_next;
          run_min  <= sgmpca_pkg::SAT_MAX;
        end else begin
          run_min  <= run_min_next;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_cost_floor: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1.first |-> res >= s1.cost)
    else $error("aggregated cost below matching cost");

  a_min_falls: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !at_zero && !s1.last |=> run_min <= $past(run_min))
    else $error("running minimum increased within a pixel");

  a_min_rearm: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1.last |=> run_min == sgmpca_pkg::SAT_MAX)
    else $error("running minimum not rearmed after pixel end");
`endif

endmodule

// ----- rtl/sgm_path_cost_aggregation.sv -----
// ----------------------------------------------------------------------------
// sgm_path_cost_aggregation
// Semi-global matching cost aggregation along one scanline path.
// ----------------------------------------------------------------------------
// Input stream s_*: one matching cost per transaction, disparities 0 to
// NUM_DISP-1 of a pixel in order, pixels in path order. s_tuser[0] on the
// disparity-0 transaction marks the first pixel of a path.
// Output stream m_*: one aggregated cost per input transaction, in order,
// with its disparity; m_tlast marks the last disparity of a pixel.
// APB port: P1 at address 0x0, P2 at address 0x4; write only while idle.
// From input to output an item passes the queue, the store read and the result
// register. One transaction per cycle is sustained while the receiver accepts;
// the rate is set by the single-port read and single-port write of the two-bank
// vector store, one disparity each per cycle.
// Reset clears the disparity count and the queue and treats the next pixel
// as a path start; P1 and P2 return to 40 and 200.
// When the receiver stalls the result register holds, the queue fills and
// s_tready drops once it is full.
// ----------------------------------------------------------------------------
module sgm_path_cost_aggregation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sgmpca_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] match_cost
  input  logic [sgmpca_pkg::IN_TUSER_W-1:0]   s_tuser,  // [0] path_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sgmpca_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [7:0] path_cost, [13:8] disparity
  output logic                                m_tlast,  // pixel_done
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sgmpca_pkg::APB_AW-1:0]       paddr,
  input  logic [sgmpca_pkg::APB_DW-1:0]       pwdata,
  output logic [sgmpca_pkg::APB_DW-1:0]       prdata,
  output logic                                pready
);

  logic [sgmpca_pkg::COST_W-1:0] small_penalty;
  logic [sgmpca_pkg::COST_W-1:0] large_penalty;
  logic                          reg_sel;
  logic                          q_full;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_valid;
  sgmpca_pkg::item_t             push_item;
  sgmpca_pkg::item_t             head_item;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == sgmpca_pkg::REG_LARGE_PENALTY)
                 ? sgmpca_pkg::APB_DW'(large_penalty)
                 : sgmpca_pkg::APB_DW'(small_penalty);

  always_ff @(posedge clk) begin
    if (rst) begin
      small_penalty <= sgmpca_pkg::SMALL_PENALTY_RST;
      large_penalty <= sgmpca_pkg::LARGE_PENALTY_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == sgmpca_pkg::REG_SMALL_PENALTY) begin
        small_penalty <= pwdata[sgmpca_pkg::COST_W-1:0];
      end else begin
        large_penalty <= pwdata[sgmpca_pkg::COST_W-1:0];
      end
    end
  end

  sgmpca_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  sgmpca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head_item)
  );

  sgmpca_back u_back (
    .clk           (clk),
    .rst           (rst),
    .small_penalty (small_penalty),
    .large_penalty (large_penalty),
    .q_valid       (q_valid),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

endmodule
